@@ src/hbridge_pwm_command_mapper_unit_defines.svh @@
// Assertion macros shared by the H-bridge command mapper RTL.
// Included by every module that carries concurrent checks; depends on nothing.
`ifndef HBRIDGE_PWM_COMMAND_MAPPER_UNIT_DEFINES_SVH
`define HBRIDGE_PWM_COMMAND_MAPPER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define HPCM_ASSERT_NOW(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("hpcm check failed");

// Next-cycle implication, checked outside reset.
`define HPCM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("hpcm check failed");

`else

`define HPCM_ASSERT_NOW(label, clk, rst_n, pre, post)
`define HPCM_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

@@ src/hpcm_pkg.sv @@
// Shared constants, codes and types of the H-bridge command mapper.
// No dependencies; used by hpcm_serdiv and the top level.
`default_nettype none

package hpcm_pkg;

  // Command scale and PWM resolution.
  localparam int FULL_SCALE       = 400;
  localparam int PWM_DUTY_SCALE   = 1024;
  localparam int HALF_SCALE       = FULL_SCALE / 2;
  localparam int MOTOR_COUNT_DEF  = 4;

  // Field widths.
  localparam int CMD_W  = 9;   // command magnitude, 0..FULL_SCALE
  localparam int REQ_W  = 10;  // signed request and mapped duty
  localparam int TICK_W = 11;  // PWM ticks, 0..PWM_DUTY_SCALE

  // Bit-serial divider geometry: quotient bits, divisor bits, dividend bits.
  localparam int DIV_Q_W = TICK_W;
  localparam int DIV_D_W = CMD_W;
  localparam int DIV_N_W = DIV_Q_W + DIV_D_W;
  localparam int DIV_C_W = $clog2(DIV_Q_W + 1);

  // Configuration register indexes.
  localparam logic REG_MIN_DUTY = 1'b0;
  localparam logic REG_DEADBAND = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [CMD_W-1:0] MIN_DUTY_RST = CMD_W'(144);
  localparam logic [CMD_W-1:0] DEADBAND_RST = CMD_W'(0);

  // Pin codes reported on pwm_pin.
  localparam logic [1:0] PIN_NONE = 2'd0;
  localparam logic [1:0] PIN_A    = 2'd1;
  localparam logic [1:0] PIN_B    = 2'd2;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_STOP = 2'd1,
    OP_READ = 2'd2
  } op_e;

  // Divider request and response.
  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] num;
    logic [DIV_D_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ src/hpcm_serdiv.sv @@
// Bit-serial restoring divider of the H-bridge command mapper.
// Depends on hpcm_pkg and the shared assertion macro header.
`default_nettype none
`include "hbridge_pwm_command_mapper_unit_defines.svh"

module hpcm_serdiv (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire hpcm_pkg::div_req_t req_i,
  output      hpcm_pkg::div_rsp_t rsp_o
);

  localparam int QW = hpcm_pkg::DIV_Q_W;
  localparam int DW = hpcm_pkg::DIV_D_W;
  localparam int CW = hpcm_pkg::DIV_C_W;

  logic [DW-1:0] rem_q, rem_d;
  logic [QW-1:0] sh_q, sh_d;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [DW:0]   trial;
  logic          fits;

  // One quotient bit per cycle: shift the next dividend bit into the remainder.
  // The caller keeps the dividend below the divisor times 2**QW, so the
  // remainder always stays below the divisor.
  always_comb begin
    trial = {rem_q, sh_q[QW-1]};
    fits  = trial >= {1'b0, den_q};
    rem_d = fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
    sh_d  = {sh_q[QW-2:0], fits};
  end

  // Sequencing and data shift registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      sh_q   <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QW);
        rem_q  <= req_i.num[QW+DW-1:QW];
        sh_q   <= req_i.num[QW-1:0];
        den_q  <= req_i.den;
      end else if (busy_q) begin
        rem_q <= rem_d;
        sh_q  <= sh_d;
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = sh_q;

  // The remainder never reaches the divisor while a division runs.
  `HPCM_ASSERT_NOW(a_rem_below_den, clk_i, rst_ni, busy_q, rem_q < den_q)
  // A new division is never launched on top of a running one.
  `HPCM_ASSERT_NOW(a_no_restart, clk_i, rst_ni, req_i.start, !busy_q)
  // Completion is a single-cycle pulse that ends the busy period.
  `HPCM_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_q, !done_q && !busy_q)

endmodule

`default_nettype wire

@@ src/hbridge_pwm_command_mapper_unit.sv @@
// Top level of the sign-magnitude H-bridge command mapper.
// Depends on hpcm_pkg and hpcm_serdiv.
`default_nettype none

// A request is taken when start is high and busy is low. A set request outside
// the deadband goes first through ST_MUL, which does the span multiply. Then
// come two passes through the shared bit-serial divider, each made of launch,
// operand load and eleven quotient bits at one bit per cycle. The first pass
// does the deadband mapping and the second the conversion to PWM ticks. A set
// request inside the deadband skips the first pass. Stop, read, unused
// operation codes and out-of-range motors go through ST_RESP straight to their
// result. Each result is shown for exactly one cycle with result_valid_o high
// and cannot be held off; busy drops in the same cycle, so the next request may
// be presented then. Configuration writes are always ready and must only be
// issued while busy is low. MOTOR_COUNT may range from 1 to 4.
module hbridge_pwm_command_mapper_unit #(
  parameter int MOTOR_COUNT = hpcm_pkg::MOTOR_COUNT_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // Request side
  input  wire logic                      start,
  output      logic                      busy,
  input  wire logic [1:0]                operation_i,
  input  wire logic [1:0]                motor_i,
  input  wire logic signed [9:0]         request_i,
  input  wire logic                      brake_i,
  // Result side
  output      logic                      result_valid_o,
  output      logic [1:0]                motor_out_o,
  output      logic [1:0]                pwm_pin_o,
  output      logic [10:0]               pwm_duty_o,
  output      logic                      pin_a_level_o,
  output      logic                      pin_b_level_o,
  output      logic signed [9:0]         mapped_duty_o,
  // Configuration write channel
  input  wire logic                      cfg_valid_i,
  output      logic                      cfg_ready_o,
  input  wire logic                      cfg_index_i,
  input  wire logic [8:0]                cfg_data_i
);

  localparam int CW   = hpcm_pkg::CMD_W;
  localparam int RW   = hpcm_pkg::REQ_W;
  localparam int NW   = hpcm_pkg::DIV_N_W;
  localparam int IdxW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  localparam logic [CW-1:0] FullCmd = CW'(hpcm_pkg::FULL_SCALE);
  localparam logic [RW-1:0] FullReq = RW'(hpcm_pkg::FULL_SCALE);
  localparam logic [4:0]    MotLim  = 5'(MOTOR_COUNT);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MAP,
    ST_TICK,
    ST_RESP
  } state_e;

  state_e            state_q;
  hpcm_pkg::op_e     op_q;
  logic [1:0]        motor_q;
  logic              brake_q;
  logic              neg_q;
  logic              in_range_q;
  logic [CW-1:0]     mag_q;
  logic [CW-1:0]     duty_q;
  logic [CW-1:0]     min_duty_q;
  logic [CW-1:0]     deadband_q;
  logic signed [RW-1:0] store_q [MOTOR_COUNT];

  hpcm_pkg::div_req_t div_req;
  hpcm_pkg::div_rsp_t div_rsp;
  logic              div_start_q;
  logic [NW-1:0]     div_num_q;
  logic [CW-1:0]     div_den_q;

  logic [CW-1:0]     lo_c;
  logic [CW-1:0]     eps_c;
  logic [CW-1:0]     span_in_c;
  logic [CW-1:0]     span_out_c;
  logic [2*CW-1:0]   prod_c;
  logic [RW-1:0]     abs_c;
  logic [CW-1:0]     req_mag_c;
  logic [RW-1:0]     sum_c;
  logic [CW-1:0]     duty_c;
  logic              neg_c;
  logic [RW-1:0]     signed_duty_c;
  logic [IdxW-1:0]   idx_c;
  logic              wr_set;
  logic              wr_stop;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_duty_q <= hpcm_pkg::MIN_DUTY_RST;
      deadband_q <= hpcm_pkg::DEADBAND_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        hpcm_pkg::REG_MIN_DUTY: min_duty_q <= cfg_data_i;
        hpcm_pkg::REG_DEADBAND: deadband_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Saturated settings and the spans of the deadband mapping.
  always_comb begin
    lo_c       = (min_duty_q > FullCmd) ? FullCmd : min_duty_q;
    eps_c      = (deadband_q >= FullCmd) ? FullCmd - CW'(1) : deadband_q;
    span_in_c  = FullCmd - eps_c;
    span_out_c = FullCmd - lo_c;
    prod_c     = (2*CW)'(mag_q - eps_c) * (2*CW)'(span_out_c);
  end

  // Magnitude of the incoming request, saturated to full scale.
  always_comb begin
    abs_c     = request_i[RW-1] ? RW'(-request_i) : request_i;
    req_mag_c = (abs_c > FullReq) ? FullCmd : abs_c[CW-1:0];
  end

  // Mapped duty once the first division is done, and its signed form.
  always_comb begin
    sum_c         = RW'(lo_c) + RW'(div_rsp.quot[CW-1:0]);
    duty_c        = (sum_c > FullReq) ? FullCmd : sum_c[CW-1:0];
    neg_c         = neg_q && (duty_q != '0);
    signed_duty_c = neg_c ? RW'(-{1'b0, duty_q}) : RW'(duty_q);
  end

  assign idx_c   = IdxW'(motor_q);
  assign wr_set  = (state_q == ST_TICK) && div_rsp.done;
  assign wr_stop = (state_q == ST_RESP) && in_range_q && (op_q == hpcm_pkg::OP_STOP);

  // Stored duty per motor.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        store_q[i] <= '0;
      end
    end else if (wr_set) begin
      store_q[idx_c] <= signed_duty_c;
    end else if (wr_stop) begin
      store_q[idx_c] <= '0;
    end
  end

  // Command sequencer with registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      op_q           <= hpcm_pkg::OP_SET;
      motor_q        <= '0;
      brake_q        <= 1'b0;
      neg_q          <= 1'b0;
      in_range_q     <= 1'b0;
      mag_q          <= '0;
      duty_q         <= '0;
      div_start_q    <= 1'b0;
      div_num_q      <= '0;
      div_den_q      <= '0;
      result_valid_o <= 1'b0;
      motor_out_o    <= '0;
      pwm_pin_o      <= hpcm_pkg::PIN_NONE;
      pwm_duty_o     <= '0;
      pin_a_level_o  <= 1'b0;
      pin_b_level_o  <= 1'b0;
      mapped_duty_o  <= '0;
    end else begin
      result_valid_o <= 1'b0;
      div_start_q    <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            op_q       <= hpcm_pkg::op_e'(operation_i);
            motor_q    <= motor_i;
            brake_q    <= brake_i;
            neg_q      <= request_i[RW-1];
            mag_q      <= req_mag_c;
            in_range_q <= 5'(motor_i) < MotLim;
            if ((5'(motor_i) < MotLim) && (operation_i == hpcm_pkg::OP_SET)) begin
              state_q <= ST_MUL;
            end else begin
              state_q <= ST_RESP;
            end
          end
        end
        ST_MUL: begin
          div_start_q <= 1'b1;
          if (mag_q <= eps_c) begin
            // Inside the deadband: a real stop, converted straight to ticks.
            duty_q    <= '0;
            div_num_q <= NW'(hpcm_pkg::HALF_SCALE);
            div_den_q <= FullCmd;
            state_q   <= ST_TICK;
          end else begin
            div_num_q <= NW'(prod_c);
            div_den_q <= span_in_c;
            state_q   <= ST_MAP;
          end
        end
        ST_MAP: begin
          if (div_rsp.done) begin
            duty_q      <= duty_c;
            div_num_q   <= NW'(duty_c) * NW'(hpcm_pkg::PWM_DUTY_SCALE)
                         + NW'(hpcm_pkg::HALF_SCALE);
            div_den_q   <= FullCmd;
            div_start_q <= 1'b1;
            state_q     <= ST_TICK;
          end
        end
        ST_TICK: begin
          if (div_rsp.done) begin
            result_valid_o <= 1'b1;
            motor_out_o    <= motor_q;
            pwm_pin_o      <= neg_c ? hpcm_pkg::PIN_B : hpcm_pkg::PIN_A;
            pwm_duty_o     <= div_rsp.quot;
            pin_a_level_o  <= 1'b0;
            pin_b_level_o  <= 1'b0;
            mapped_duty_o  <= signed_duty_c;
            state_q        <= ST_IDLE;
          end
        end
        ST_RESP: begin
          result_valid_o <= 1'b1;
          motor_out_o    <= motor_q;
          pwm_pin_o      <= hpcm_pkg::PIN_NONE;
          pwm_duty_o     <= '0;
          pin_a_level_o  <= 1'b0;
          pin_b_level_o  <= 1'b0;
          mapped_duty_o  <= '0;
          if (in_range_q) begin
            case (op_q)
              hpcm_pkg::OP_STOP: begin
                pin_a_level_o <= brake_q;
                pin_b_level_o <= brake_q;
              end
              hpcm_pkg::OP_READ: begin
                mapped_duty_o <= store_q[idx_c];
              end
              default: ;
            endcase
          end
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy = (state_q != ST_IDLE);

  // Shared bit-serial divider.
  assign div_req.start = div_start_q;
  assign div_req.num   = div_num_q;
  assign div_req.den   = div_den_q;

  hpcm_serdiv u_serdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for the H-bridge command mapper, top level testbench.
// Depends on hpcm_pkg and hbridge_pwm_command_mapper_unit; drives directed and random
// requests and checks every result against a built-in model or a hand-written result.
module testbench;
  import hpcm_pkg::*;

  localparam int MOTORS = MOTOR_COUNT_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 100;

  // One result of the block, field by field.
  typedef struct packed {
    logic [1:0]  motor;
    logic [1:0]  pin;
    logic [10:0] ticks;
    logic        level_a;
    logic        level_b;
    logic [9:0]  duty;
  } drive_result_t;

  // One request, with an optional hand-written result.
  typedef struct packed {
    logic [1:0]    op;
    logic [1:0]    motor;
    logic [9:0]    request;
    logic          brake;
    logic          typed;
    drive_result_t result;
  } motor_request_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        operation_i = '0;
  logic [1:0]        motor_i = '0;
  logic signed [9:0] request_i = '0;
  logic              brake_i = 1'b0;
  logic              result_valid_o;
  logic [1:0]        motor_out_o;
  logic [1:0]        pwm_pin_o;
  logic [10:0]       pwm_duty_o;
  logic              pin_a_level_o;
  logic              pin_b_level_o;
  logic signed [9:0] mapped_duty_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_index_i = 1'b0;
  logic [8:0]        cfg_data_i = '0;

  // Hand-written result travelling alongside the request ports.
  logic          typed_valid = 1'b0;
  drive_result_t typed_result = '0;

  // Mirror of the block state and registers.
  logic [8:0]        min_duty_setting = MIN_DUTY_RST;
  logic [8:0]        deadband_setting = DEADBAND_RST;
  logic signed [9:0] held_duty [MOTORS];

  drive_result_t  pending_results [$];
  motor_request_t directed_rows [$];
  int             idle_pct = 31;
  int             error_count = 0;

  int unsigned phase_min_duty [RANDOM_PHASES] = '{144, 0, 400, 511, 0, 400, 0, 200};
  int unsigned phase_deadband [RANDOM_PHASES] = '{0, 0, 399, 511, 399, 0, 0, 100};

  hbridge_pwm_command_mapper_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .motor_i        (motor_i),
    .request_i      (request_i),
    .brake_i        (brake_i),
    .result_valid_o (result_valid_o),
    .motor_out_o    (motor_out_o),
    .pwm_pin_o      (pwm_pin_o),
    .pwm_duty_o     (pwm_duty_o),
    .pin_a_level_o  (pin_a_level_o),
    .pin_b_level_o  (pin_b_level_o),
    .mapped_duty_o  (mapped_duty_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Free-running clock, period 10.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Computes the result of one accepted request and updates the mirrored state.
  function automatic drive_result_t predict_drive(input logic [1:0] op, input logic [1:0] mot,
                                                  input logic signed [9:0] req,
                                                  input logic brk);
    drive_result_t res;
    int lo, eps, demand, mag, duty, signed_duty;
    res = '0;
    res.motor = mot;
    if (int'(mot) >= MOTORS) return res;
    case (op)
      OP_SET: begin
        lo = (min_duty_setting > FULL_SCALE) ? FULL_SCALE : int'(min_duty_setting);
        eps = (deadband_setting >= FULL_SCALE) ? FULL_SCALE - 1 : int'(deadband_setting);
        demand = req;
        if (demand > FULL_SCALE) demand = FULL_SCALE;
        if (demand < -FULL_SCALE) demand = -FULL_SCALE;
        mag = (demand < 0) ? -demand : demand;
        // Inside the deadband the motor gets a real zero, otherwise the span is rescaled.
        if (mag <= eps) begin
          duty = 0;
        end else begin
          duty = lo + ((mag - eps) * (FULL_SCALE - lo)) / (FULL_SCALE - eps);
          if (duty > FULL_SCALE) duty = FULL_SCALE;
        end
        signed_duty = (demand < 0) ? -duty : duty;
        res.pin = (signed_duty < 0) ? PIN_B : PIN_A;
        res.ticks = 11'((duty * PWM_DUTY_SCALE + HALF_SCALE) / FULL_SCALE);
        res.duty = 10'(signed_duty);
        held_duty[mot] = 10'(signed_duty);
      end
      OP_STOP: begin
        res.level_a = brk;
        res.level_b = brk;
        held_duty[mot] = '0;
      end
      OP_READ: begin
        res.duty = held_duty[mot];
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  task automatic check_field(input string label, input int want, input int got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
    end
  endtask

  // Checks each result against the oldest expectation, then records new requests.
  always @(posedge clk_i) begin : result_monitor
    drive_result_t want;
    drive_result_t model;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (pending_results.size() == 0) begin
          error_count++;
          $display("%0t: result for motor %0d with no request outstanding",
                   $time, motor_out_o);
        end else begin
          want = pending_results.pop_front();
          check_field("motor_out", want.motor, motor_out_o);
          check_field("pwm_pin", want.pin, pwm_pin_o);
          check_field("pwm_duty", want.ticks, pwm_duty_o);
          check_field("pin_a_level", want.level_a, pin_a_level_o);
          check_field("pin_b_level", want.level_b, pin_b_level_o);
          check_field("mapped_duty", int'($signed(want.duty)), int'(mapped_duty_o));
        end
      end
      if (start && !busy) begin
        model = predict_drive(operation_i, motor_i, request_i, brake_i);
        pending_results.push_back(typed_valid ? typed_result : model);
      end
    end
  end

  task automatic add_row(input logic [1:0] op, input int mot, input int req, input logic brk,
                         input logic typed, input logic [1:0] pin, input int ticks,
                         input logic lvl_a, input logic lvl_b, input int duty);
    motor_request_t row;
    row.op = op;
    row.motor = 2'(mot);
    row.request = 10'(req);
    row.brake = brk;
    row.typed = typed;
    row.result = '{2'(mot), pin, 11'(ticks), lvl_a, lvl_b, 10'(duty)};
    directed_rows.push_back(row);
  endtask

  // Presents one request after a random gap and waits for it to be taken.
  task automatic send_request(input motor_request_t row);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      operation_i <= 2'($urandom);
      motor_i <= 2'($urandom);
      request_i <= 10'($urandom);
      @(posedge clk_i);
    end
    start <= 1'b1;
    operation_i <= row.op;
    motor_i <= row.motor;
    request_i <= row.request;
    brake_i <= row.brake;
    typed_valid <= row.typed;
    typed_result <= row.result;
    do @(posedge clk_i); while (busy);
  endtask

  // Holds requests off until every outstanding result has come back.
  task automatic wait_until_drained();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Writes both mapping registers back to back; only called while the block is idle.
  task automatic load_mapping_registers(input logic [8:0] lo, input logic [8:0] band);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_MIN_DUTY;
    cfg_data_i <= lo;
    do @(posedge clk_i); while (!cfg_ready_o);
    min_duty_setting = lo;
    cfg_index_i <= REG_DEADBAND;
    cfg_data_i <= band;
    do @(posedge clk_i); while (!cfg_ready_o);
    deadband_setting = band;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random request biased toward the deadband edge and the saturation points.
  function automatic motor_request_t random_request();
    motor_request_t row;
    int sel, eps, demand;
    row = '0;
    eps = (deadband_setting >= FULL_SCALE) ? FULL_SCALE - 1 : int'(deadband_setting);
    sel = $urandom_range(99);
    if (sel < 60) row.op = OP_SET;
    else if (sel < 75) row.op = OP_STOP;
    else if (sel < 95) row.op = OP_READ;
    else row.op = OP_UNUSED;
    case ($urandom_range(7))
      0, 1, 2: demand = int'($urandom_range(1023)) - 512;
      3, 4: demand = int'($urandom_range(800)) - FULL_SCALE;
      5: demand = eps + int'($urandom_range(1));
      6: demand = FULL_SCALE - 1 + int'($urandom_range(2));
      default: begin
        case ($urandom_range(4))
          0: demand = 0;
          1: demand = 511;
          2: demand = -512;
          3: demand = 1;
          default: demand = -1;
        endcase
      end
    endcase
    if ($urandom_range(3) == 0 && demand > 0) demand = -demand;
    row.motor = 2'($urandom);
    row.request = 10'(demand);
    row.brake = 1'($urandom);
    return row;
  endfunction

  // Main sequence: reset, directed table, then random phases over several settings.
  initial begin
    for (int m = 0; m < MOTORS; m++) held_duty[m] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with the reset settings: saturation, stop, read and odd codes.
    add_row(OP_READ, 0, 0, 1'b0, 1'b1, PIN_NONE, 0, 1'b0, 1'b0, 0);
    add_row(OP_SET, 0, 511, 1'b0, 1'b1, PIN_A, 1024, 1'b0, 1'b0, 400);
    add_row(OP_SET, 1, -512, 1'b1, 1'b1, PIN_B, 1024, 1'b0, 1'b0, -400);
    add_row(OP_READ, 1, 0, 1'b0, 1'b1, PIN_NONE, 0, 1'b0, 1'b0, -400);
    add_row(OP_STOP, 0, 0, 1'b1, 1'b1, PIN_NONE, 0, 1'b1, 1'b1, 0);
    add_row(OP_READ, 0, 0, 1'b0, 1'b1, PIN_NONE, 0, 1'b0, 1'b0, 0);
    add_row(OP_STOP, 2, 0, 1'b0, 1'b1, PIN_NONE, 0, 1'b0, 1'b0, 0);
    add_row(OP_UNUSED, 3, 511, 1'b1, 1'b1, PIN_NONE, 0, 1'b0, 1'b0, 0);
    add_row(OP_SET, 3, 0, 1'b0, 1'b1, PIN_A, 0, 1'b0, 1'b0, 0);
    add_row(OP_SET, 2, 400, 1'b0, 1'b1, PIN_A, 1024, 1'b0, 1'b0, 400);
    add_row(OP_SET, 2, -400, 1'b0, 1'b1, PIN_B, 1024, 1'b0, 1'b0, -400);
    add_row(OP_SET, 3, 401, 1'b0, 1'b0, PIN_NONE, 0, 1'b0, 1'b0, 0);
    add_row(OP_SET, 3, -401, 1'b0, 1'b0, PIN_NONE, 0, 1'b0, 1'b0, 0);
    add_row(OP_SET, 0, 399, 1'b0, 1'b0, PIN_NONE, 0, 1'b0, 1'b0, 0);
    add_row(OP_SET, 1, 1, 1'b0, 1'b0, PIN_NONE, 0, 1'b0, 1'b0, 0);
    add_row(OP_SET, 2, -1, 1'b1, 1'b0, PIN_NONE, 0, 1'b0, 1'b0, 0);
    add_row(OP_SET, 3, 200, 1'b0, 1'b0, PIN_NONE, 0, 1'b0, 1'b0, 0);
    add_row(OP_SET, 0, -255, 1'b0, 1'b0, PIN_NONE, 0, 1'b0, 1'b0, 0);
    add_row(OP_READ, 2, 0, 1'b0, 1'b0, PIN_NONE, 0, 1'b0, 1'b0, 0);
    add_row(OP_READ, 3, -1, 1'b1, 1'b0, PIN_NONE, 0, 1'b0, 1'b0, 0);
    add_row(OP_STOP, 1, 0, 1'b1, 1'b1, PIN_NONE, 0, 1'b1, 1'b1, 0);
    add_row(OP_READ, 1, 0, 1'b0, 1'b1, PIN_NONE, 0, 1'b0, 1'b0, 0);
    foreach (directed_rows[i]) send_request(directed_rows[i]);

    // Random phases: the sender idles rarely, then often, then not at all.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      idle_pct = (phase < 3) ? 31 : (phase < 6) ? 69 : 0;
      if (phase == 6) begin
        phase_min_duty[phase] = $urandom_range(511);
        phase_deadband[phase] = $urandom_range(511);
      end
      wait_until_drained();
      load_mapping_registers(9'(phase_min_duty[phase]), 9'(phase_deadband[phase]));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_request(random_request());
        if ($urandom_range(49) == 0) wait_until_drained();
      end
    end

    wait_until_drained();
    repeat (40) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/hpcm_pkg.sv
src/hpcm_serdiv.sv
src/hbridge_pwm_command_mapper_unit.sv
test/testbench.sv
